// ===== design/lbp_pkg.sv =====
// lbp_pkg: sizes, result type and the 3x3 pattern function of the LBP stream.
// Used by local_binary_pattern_stream; depends on nothing.
package lbp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int AW         = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 11;
	localparam int DEF_DIM    = 5;
	localparam int PIX_W      = 8;
	localparam int CODE_W     = 8;
	localparam int POS_W      = 10;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;
	localparam int MAX_RES    = 2;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [2:0] col_t;
	// n[row][col]: row 0 up, col 0 left, centre n[1][1]
	typedef pix_t [2:0][2:0] win_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic              last;
	} res_t;

	function automatic logic [CODE_W-1:0] lbp_code(input win_t n);
		logic [CODE_W-1:0] v;
		v[7] = (n[0][1] >= n[1][1]);
		v[6] = (n[0][2] >= n[1][1]);
		v[5] = (n[1][2] >= n[1][1]);
		v[4] = (n[2][2] >= n[1][1]);
		v[3] = (n[2][1] >= n[1][1]);
		v[2] = (n[2][0] >= n[1][1]);
		v[1] = (n[1][0] >= n[1][1]);
		v[0] = (n[0][0] >= n[1][1]);
		return v;
	endfunction

endpackage

// ===== design/local_binary_pattern_stream.sv =====
// Streaming 3x3 local binary pattern: APB registers, line buffers, window and result queue.
// Depends on lbp_pkg.
//
// Accepts one pixel beat per clock in raster order and returns the code of centre (r-1, c-1)
// when pixel (r, c) is taken; the last pixel of a row also returns (r-1, W-1), and after the
// frame W drain beats return the last row. The codes of a beat taken at one clock edge are
// written into the 8-entry result queue at the following edge. The queue drains one beat per
// clock and a row of W pixels gives W codes, so with the output side flat out the input takes
// a pixel every clock; when the output stalls, the input stops once the queue could not hold
// two more codes behind the beat in flight.
// Each line buffer is a 1024 x 8 memory with one write and two registered reads per clock;
// there is no clearing pass after reset. A register write restarts the frame and must only be
// issued while the block is idle. Out-of-range sizes are clamped to 1..1024.
module local_binary_pattern_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        req_type,
	input  logic [7:0]  pixel,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  code,
	output logic [9:0]  row,
	output logic [9:0]  col,
	output logic        last
);

	typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_idx_t;
	typedef enum logic {REQ_PIXEL = 1'b0, REQ_DRAIN = 1'b1} req_kind_t;

	typedef struct packed {
		lbp_pkg::pix_t                px;
		logic [lbp_pkg::AW-1:0]       c;
		logic [lbp_pkg::POS_W-1:0]    r_out;
		logic                         r1;
		logic                         abv_ok;
		logic                         c1;
		logic                         c_end;
	} s1_t;

	// registers
	logic [lbp_pkg::DIM_W-1:0] fw_q, fh_q, w_eff, h_eff;
	logic                      cfg_wr;
	reg_idx_t                  wr_idx;

	// counters
	logic [lbp_pkg::AW-1:0]    col_q, col_b;
	logic [lbp_pkg::DIM_W-1:0] row_q, col_ext;
	logic                      col_end, in_drain, acc, take_pix, take_drn;

	// stage 1
	s1_t            s1_d, s1_q;
	logic           s1_pix_q, s1_drn_q;
	logic [31:0]    h_m1, r_m1;

	// line buffers
	lbp_pkg::pix_t  mid_mem [lbp_pkg::MAX_WIDTH];
	lbp_pkg::pix_t  abv_mem [lbp_pkg::MAX_WIDTH];
	lbp_pkg::pix_t  mid_a_q, mid_b_q, abv_a_q, abv_b_q, byp_mid_q, byp_abv_q;
	logic           hit_a_q, hit_b_q;
	lbp_pkg::pix_t  mid_c, mid_n, abv_c, abv_n;

	// window state
	lbp_pkg::col_t  win1_q, win2_q;
	lbp_pkg::pix_t  dp_mid_q, dp_abv_q;
	lbp_pkg::win_t  pw, ew, dw;

	// results
	lbp_pkg::res_t               res0, res1, head;
	lbp_pkg::res_t               fifo_q [lbp_pkg::FIFO_DEPTH];
	logic [lbp_pkg::FIFO_AW-1:0] wp_q, rp_q;
	logic [lbp_pkg::FIFO_CW-1:0] cnt_q, n_push;
	logic [lbp_pkg::FIFO_CW:0]   fill_sum;
	logic                        pop, has_a, has_b;
	logic [31:0]                 c32, cm32;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign wr_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (wr_idx)
			REG_WIDTH:  prdata = {{(32-lbp_pkg::DIM_W){1'b0}}, fw_q};
			REG_HEIGHT: prdata = {{(32-lbp_pkg::DIM_W){1'b0}}, fh_q};
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		priority if (fw_q == '0) begin
			w_eff = lbp_pkg::DIM_W'(1);
		end else if (fw_q > lbp_pkg::DIM_W'(lbp_pkg::MAX_WIDTH)) begin
			w_eff = lbp_pkg::DIM_W'(lbp_pkg::MAX_WIDTH);
		end else begin
			w_eff = fw_q;
		end
		priority if (fh_q == '0) begin
			h_eff = lbp_pkg::DIM_W'(1);
		end else if (fh_q > lbp_pkg::DIM_W'(lbp_pkg::MAX_HEIGHT)) begin
			h_eff = lbp_pkg::DIM_W'(lbp_pkg::MAX_HEIGHT);
		end else begin
			h_eff = fh_q;
		end
	end

	// ---------------- accept ----------------
	assign col_ext  = {{(lbp_pkg::DIM_W-lbp_pkg::AW){1'b0}}, col_q};
	assign col_end  = (col_ext == w_eff - 1'b1);
	assign col_b    = col_q + 1'b1;
	assign in_drain = (row_q >= h_eff);
	assign acc      = req_valid & req_ready;
	assign take_pix = acc & ~in_drain & (req_kind_t'(req_type) == REQ_PIXEL);
	assign take_drn = acc & in_drain & (req_kind_t'(req_type) == REQ_DRAIN);
	assign h_m1     = {{(32-lbp_pkg::DIM_W){1'b0}}, h_eff} - 32'd1;
	assign r_m1     = {{(32-lbp_pkg::DIM_W){1'b0}}, row_q} - 32'd1;

	always_comb begin
		s1_d.px     = pixel;
		s1_d.c      = col_q;
		s1_d.r_out  = in_drain ? h_m1[lbp_pkg::POS_W-1:0] : r_m1[lbp_pkg::POS_W-1:0];
		s1_d.r1     = (row_q != '0);
		s1_d.abv_ok = in_drain ? (h_eff >= 2) : (row_q >= 2);
		s1_d.c1     = (col_q != '0);
		s1_d.c_end  = col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= lbp_pkg::DIM_W'(lbp_pkg::DEF_DIM);
			fh_q     <= lbp_pkg::DIM_W'(lbp_pkg::DEF_DIM);
			col_q    <= '0;
			row_q    <= '0;
			s1_pix_q <= 1'b0;
			s1_drn_q <= 1'b0;
		end else begin
			s1_pix_q <= take_pix;
			s1_drn_q <= take_drn;
			if (cfg_wr) begin
				unique case (wr_idx)
					REG_WIDTH:  fw_q <= pwdata[lbp_pkg::DIM_W-1:0];
					REG_HEIGHT: fh_q <= pwdata[lbp_pkg::DIM_W-1:0];
					default:    fw_q <= fw_q;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (take_pix) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_b;
				end
			end else if (take_drn) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= col_b;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_q <= s1_d;
		end
	end

	// ---------------- line buffers ----------------
	// reads see the old word; the write of the beat in stage 1 is bypassed
	always_ff @(posedge clk) begin
		if (s1_pix_q) begin
			mid_mem[s1_q.c] <= s1_q.px;
			abv_mem[s1_q.c] <= mid_c;
		end
		mid_a_q   <= mid_mem[col_q];
		mid_b_q   <= mid_mem[col_b];
		abv_a_q   <= abv_mem[col_q];
		abv_b_q   <= abv_mem[col_b];
		hit_a_q   <= s1_pix_q && (s1_q.c == col_q);
		hit_b_q   <= s1_pix_q && (s1_q.c == col_b);
		byp_mid_q <= s1_q.px;
		byp_abv_q <= mid_c;
	end

	assign mid_c = hit_a_q ? byp_mid_q : mid_a_q;
	assign abv_c = hit_a_q ? byp_abv_q : abv_a_q;
	assign mid_n = hit_b_q ? byp_mid_q : mid_b_q;
	assign abv_n = hit_b_q ? byp_abv_q : abv_b_q;

	// ---------------- window and codes ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pw[i][0] = s1_q.c1 ? win1_q[i] : '0;
			pw[i][1] = s1_q.c1 ? win2_q[i] : '0;
		end
		pw[0][2] = s1_q.abv_ok ? abv_c : '0;
		pw[1][2] = s1_q.r1 ? mid_c : '0;
		pw[2][2] = s1_q.px;
		for (int i = 0; i < 3; i++) begin
			ew[i][0] = pw[i][1];
			ew[i][1] = pw[i][2];
			ew[i][2] = '0;
		end
		dw[0][0] = (s1_q.c1 && s1_q.abv_ok) ? dp_abv_q : '0;
		dw[0][1] = s1_q.abv_ok ? abv_c : '0;
		dw[0][2] = (!s1_q.c_end && s1_q.abv_ok) ? abv_n : '0;
		dw[1][0] = s1_q.c1 ? dp_mid_q : '0;
		dw[1][1] = mid_c;
		dw[1][2] = !s1_q.c_end ? mid_n : '0;
		dw[2]    = '0;
	end

	assign c32   = {{(32-lbp_pkg::AW){1'b0}}, s1_q.c};
	assign cm32  = c32 - 32'd1;
	assign has_a = s1_q.r1 & s1_q.c1;
	assign has_b = s1_q.r1 & s1_q.c_end;

	always_comb begin
		res0   = '0;
		res1   = '0;
		n_push = '0;
		if (s1_drn_q) begin
			res0   = '{lbp_pkg::lbp_code(dw), s1_q.r_out, c32[lbp_pkg::POS_W-1:0], 1'b1};
			n_push = lbp_pkg::FIFO_CW'(1);
		end else if (s1_pix_q) begin
			res1 = '{lbp_pkg::lbp_code(ew), s1_q.r_out, c32[lbp_pkg::POS_W-1:0], 1'b1};
			if (has_a) begin
				res0   = '{lbp_pkg::lbp_code(pw), s1_q.r_out, cm32[lbp_pkg::POS_W-1:0], ~has_b};
				n_push = has_b ? lbp_pkg::FIFO_CW'(2) : lbp_pkg::FIFO_CW'(1);
			end else if (has_b) begin
				res0   = res1;
				n_push = lbp_pkg::FIFO_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_pix_q) begin
			for (int i = 0; i < 3; i++) begin
				win1_q[i] <= pw[i][1];
				win2_q[i] <= pw[i][2];
			end
		end
		if (s1_drn_q) begin
			dp_mid_q <= mid_c;
			dp_abv_q <= abv_c;
		end
	end

	// ---------------- result queue ----------------
	assign pop       = res_valid & res_ready;
	assign res_valid = (cnt_q != '0);
	assign fill_sum  = {1'b0, cnt_q} + {1'b0, n_push};
	assign req_ready = (fill_sum <= lbp_pkg::FIFO_DEPTH - lbp_pkg::MAX_RES);

	always_ff @(posedge clk) begin
		if (n_push != '0) begin
			fifo_q[wp_q] <= res0;
		end
		if (n_push == lbp_pkg::FIFO_CW'(lbp_pkg::MAX_RES)) begin
			fifo_q[wp_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[lbp_pkg::FIFO_AW-1:0];
			rp_q  <= rp_q + {{(lbp_pkg::FIFO_AW-1){1'b0}}, pop};
			cnt_q <= cnt_q + n_push - {{(lbp_pkg::FIFO_CW-1){1'b0}}, pop};
		end
	end

	assign head = fifo_q[rp_q];
	assign code = head.code;
	assign row  = head.row;
	assign col  = head.col;
	assign last = head.last;

	// ---------------- assertions ----------------
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lbp_pkg::FIFO_CW'(lbp_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_ext < w_eff)
		else $error("column counter beyond frame width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_eff)
		else $error("row counter beyond frame height");

	a_drain_one: assert property (@(posedge clk) disable iff (!arst_n)
		s1_drn_q |-> (n_push == 1 && !s1_pix_q))
		else $error("drain beat must give exactly one result");

	a_pix_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take_pix && !cfg_wr && row_q != '0 && col_q != '0) |=> (n_push != '0))
		else $error("interior pixel gave no result");

endmodule

// ===== tb/lbp_tb_pkg.sv =====
`timescale 1ns / 100ps
// lbp_tb_pkg: request kinds and register addresses shared by the LBP stream testbench.
// Depends on nothing.
package lbp_tb_pkg;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_kind_e;

	localparam logic [2:0] WIDTH_ADDR  = 3'd0;
	localparam logic [2:0] HEIGHT_ADDR = 3'd4;

endpackage

// ===== tb/lbp_checker.sv =====
`timescale 1ns / 100ps
// lbp_checker: watches the register port and both beat channels of local_binary_pattern_stream,
// predicts every code from its own line buffers and 3x3 window, and counts mismatches.
// Depends on lbp_pkg and lbp_tb_pkg.
module lbp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic        req_type,
	input  logic [7:0]  pixel,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [7:0]  code,
	input  logic [9:0]  row,
	input  logic [9:0]  col,
	input  logic        last,
	output int          errors,
	output int          pending
);
	import lbp_pkg::*;
	import lbp_tb_pkg::*;

	// code bit b compares window[row][col] taken from these 2-bit slices with the centre
	localparam logic [15:0] NB_ROW = {2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0};
	localparam logic [15:0] NB_COL = {2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};

	logic [DIM_W-1:0] width_reg  = DIM_W'(DEF_DIM);
	logic [DIM_W-1:0] height_reg = DIM_W'(DEF_DIM);
	pix_t above_line  [MAX_WIDTH];
	pix_t middle_line [MAX_WIDTH];
	int   col_pos = 0;
	int   row_pos = 0;
	win_t win = '0;
	res_t code_q [$];

	function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		if (v == 0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic res_t make_code(input win_t n, input int r, input int c);
		res_t e;
		int b;
		for (b = 0; b < 8; b++)
			e.code[b] = n[NB_ROW[2*b +: 2]][NB_COL[2*b +: 2]] >= n[1][1];
		e.row  = POS_W'(r);
		e.col  = POS_W'(c);
		e.last = 1'b0;
		return e;
	endfunction

	task automatic restart_frame;
		col_pos = 0;
		row_pos = 0;
		win = '0;
	endtask

	task automatic predict_beat(input logic kind, input pix_t px);
		int w, h, x, i, found;
		win_t n;
		res_t codes_now [2];
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		found = 0;
		n = '0;
		if (row_pos >= h) begin
			if (kind == REQ_DRAIN && col_pos < w) begin
				for (i = 0; i < 3; i++) begin
					x = col_pos + i - 1;
					if (x >= 0 && x < w) begin
						n[1][i] = middle_line[x];
						if (h >= 2)
							n[0][i] = above_line[x];
					end
				end
				codes_now[0] = make_code(n, h - 1, col_pos);
				found = 1;
				col_pos++;
				if (col_pos >= w)
					restart_frame();
			end
		end else if (kind == REQ_PIXEL && col_pos < w) begin
			if (col_pos == 0)
				win = '0;
			for (i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = (row_pos >= 2) ? above_line[col_pos] : '0;
			win[1][2] = (row_pos >= 1) ? middle_line[col_pos] : '0;
			win[2][2] = px;
			above_line[col_pos]  = middle_line[col_pos];
			middle_line[col_pos] = px;
			if (row_pos >= 1) begin
				if (col_pos >= 1) begin
					codes_now[found] = make_code(win, row_pos - 1, col_pos - 1);
					found++;
				end
				// row end: right neighbours fall outside the frame
				if (col_pos == w - 1) begin
					for (i = 0; i < 3; i++) begin
						n[i][0] = win[i][1];
						n[i][1] = win[i][2];
						n[i][2] = '0;
					end
					codes_now[found] = make_code(n, row_pos - 1, col_pos);
					found++;
				end
			end
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
		end
		if (found > 0)
			codes_now[found - 1].last = 1'b1;
		for (i = 0; i < found; i++)
			code_q.push_back(codes_now[i]);
	endtask

	function automatic void check_field(input string name, input int expected, input int actual,
			input res_t ctx);
		if (expected != actual) begin
			errors++;
			$display("%0t: %s mismatch at row %0d col %0d, expected %0d, actual %0d",
				$time, name, ctx.row, ctx.col, expected, actual);
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == WIDTH_ADDR) begin
					width_reg = pwdata[DIM_W-1:0];
					restart_frame();
				end else if (paddr == HEIGHT_ADDR) begin
					height_reg = pwdata[DIM_W-1:0];
					restart_frame();
				end
			end
			if (req_valid && req_ready)
				predict_beat(req_type, pixel);
			if (res_valid && res_ready) begin
				if (code_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, actual code %0d row %0d col %0d last %0d",
						$time, code, row, col, last);
				end else begin
					want = code_q.pop_front();
					check_field("code", int'(want.code), int'(code), want);
					check_field("row", int'(want.row), int'(row), want);
					check_field("col", int'(want.col), int'(col), want);
					check_field("last", int'(want.last), int'(last), want);
				end
			end
			pending = code_q.size();
		end
	end

endmodule

// ===== tb/local_binary_pattern_stream_tb.sv =====
`timescale 1ns / 100ps
// local_binary_pattern_stream_tb: drives frames, drain beats and register writes into the LBP
// stream with random idling, and reports the verdict. Depends on lbp_pkg, lbp_tb_pkg, lbp_checker.
module local_binary_pattern_stream_tb;
	import lbp_pkg::*;
	import lbp_tb_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_BEATS  = 480;
	localparam int MIN_FRAMES    = 5;

	typedef enum {FLAT_OUT, COIN_FLIP, RARE_STALL, MOSTLY_STALLED} rx_mode_e;
	typedef enum {ANY_VALUE, NARROW, EXTREMES, FLAT} pixel_look_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic        req_type  = REQ_PIXEL;
	logic [7:0]  pixel     = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [7:0]  code;
	logic [9:0]  row;
	logic [9:0]  col;
	logic        last;
	int          errors;
	int          pending;

	int burst_left    = 0;
	int beats_counted = 0;
	int hold_requests = 0;

	local_binary_pattern_stream dut (.*);

	lbp_checker checker_i (.*);

	initial forever #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : receiver
		rx_mode_e mode;
		int seg_left, hold_left, holds_done;
		mode = FLAT_OUT;
		seg_left = 0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				hold_left = HOLD_CYCLES;
				holds_done = hold_requests;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 200);
				end
				seg_left--;
				case (mode)
					FLAT_OUT:   res_ready <= 1'b1;
					COIN_FLIP:  res_ready <= 1'($urandom_range(0, 1));
					RARE_STALL: res_ready <= ($urandom_range(0, 7) != 0);
					default:    res_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic [7:0] pick_pixel(input pixel_look_e look);
		case (look)
			NARROW:   return 8'($urandom_range(0, 3));
			EXTREMES: return $urandom_range(0, 1) ? 8'hff : 8'h00;
			FLAT:     return 8'($urandom_range(126, 129));
			default:  return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [31:0] high_junk;
		return ($urandom_range(0, 3) == 0) ? ($urandom & 32'hffff_f800) : 32'h0;
	endfunction

	task automatic send_beat(input logic kind, input logic [7:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		pixel     <= value;
		do @(posedge clk); while (!req_ready);
		burst_left--;
	endtask

	task automatic wait_idle;
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_frame(input int w, input int h);
		wait_idle();
		write_reg(WIDTH_ADDR, high_junk() | 32'(w));
		write_reg(HEIGHT_ADDR, high_junk() | 32'(h));
	endtask

	// w and h are the clamped sizes; beats below w*h are pixels, the rest drains
	task automatic send_frame(input int w, input int h, input int beats, input bit noisy);
		int i;
		pixel_look_e look;
		look = pixel_look_e'($urandom_range(0, 3));
		for (i = 0; i < beats; i++) begin
			if (noisy && $urandom_range(0, 11) == 0)
				send_beat(i < w * h ? REQ_DRAIN : REQ_PIXEL, 8'($urandom));
			send_beat(i < w * h ? REQ_PIXEL : REQ_DRAIN, pick_pixel(look));
		end
		beats_counted += beats;
	endtask

	initial begin
		int w, h, beats, frames;
		bit whole, pressure;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset size is 5 wide; cut off early in row one
		send_beat(REQ_PIXEL, 8'd0);
		send_beat(REQ_PIXEL, 8'd255);
		send_beat(REQ_PIXEL, 8'd255);
		send_beat(REQ_PIXEL, 8'd0);
		send_beat(REQ_PIXEL, 8'd128);
		send_beat(REQ_PIXEL, 8'd255);
		send_beat(REQ_PIXEL, 8'd0);

		set_frame(3, 3);
		send_beat(REQ_DRAIN, 8'hff);
		send_beat(REQ_PIXEL, 8'd0);
		send_beat(REQ_PIXEL, 8'd255);
		send_beat(REQ_PIXEL, 8'd0);
		send_beat(REQ_PIXEL, 8'd255);
		send_beat(REQ_PIXEL, 8'd0);
		send_beat(REQ_PIXEL, 8'd255);
		send_beat(REQ_PIXEL, 8'd128);
		send_beat(REQ_PIXEL, 8'd128);
		send_beat(REQ_PIXEL, 8'd0);
		send_beat(REQ_PIXEL, 8'h55);
		send_beat(REQ_DRAIN, 8'h00);
		send_beat(REQ_DRAIN, 8'hff);
		send_beat(REQ_DRAIN, 8'h3c);
		send_beat(REQ_DRAIN, 8'h81);

		set_frame(1, 3);
		send_beat(REQ_PIXEL, 8'd0);
		send_beat(REQ_PIXEL, 8'd255);
		send_beat(REQ_PIXEL, 8'd7);
		send_beat(REQ_DRAIN, 8'd0);

		w = 1;
		h = 3;
		whole = 1'b1;
		frames = 0;
		while (beats_counted < RANDOM_BEATS || frames < MIN_FRAMES) begin
			pressure = (frames == 4);
			if (pressure || !whole || $urandom_range(0, 3) != 0) begin
				w = $urandom_range(pressure ? 4 : 1, 16);
				h = $urandom_range(pressure ? 4 : 1, 10);
				if (!pressure && $urandom_range(0, 9) == 0)
					w = $urandom_range(17, 40);
				set_frame(w, h);
			end
			beats = w * h + w;
			whole = pressure || $urandom_range(0, 7) != 0;
			if (!whole)
				beats = $urandom_range(0, beats - 1);
			if (pressure)
				hold_requests++;
			send_frame(w, h, beats, $urandom_range(0, 2) == 0);
			frames++;
		end

		// size extremes, out-of-range values clamp; the two large frames are cut short
		set_frame(0, 2047);
		send_frame(1, 1024, 150, 1'b0);
		set_frame(2047, 2);
		send_frame(1024, 2, 150, 1'b1);
		set_frame(1, 1);
		send_frame(1, 1, 2, 1'b1);

		wait_idle();
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lbp_pkg.sv
design/local_binary_pattern_stream.sv
tb/lbp_tb_pkg.sv
tb/lbp_checker.sv
tb/local_binary_pattern_stream_tb.sv
